// ----- src/scss_pkg.sv -----
`timescale 1ns / 1ps

package scss_pkg;

  // Default counter widths for source position tracking.
  localparam int unsigned DefLineBits   = 24;
  localparam int unsigned DefColumnBits = 16;

  // Widths of the position fields in a result word.
  localparam int unsigned SrcLineW   = 24;
  localparam int unsigned SrcColumnW = 16;

  // Characters the splitter reacts to.
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // End-of-input status codes.
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_COMMENT = 3'd1;
  localparam logic [2:0] STAT_OPEN    = 3'd2;
  localparam logic [2:0] STAT_DQUOTE  = 3'd3;
  localparam logic [2:0] STAT_SQUOTE  = 3'd4;

  // Input word: one source byte or the end-of-input mark.
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]            out_kind;
    logic [7:0]            out_char;
    logic                  starts_statement;
    logic [SrcLineW-1:0]   src_line;
    logic [SrcColumnW-1:0] src_column;
    logic [2:0]            status;
    logic                  last;
  } out_word_t;

  // ASCII letters and digits only.
  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

// ----- src/script_comment_strip_statement_split_core.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_ready_o    in_data_i  (char_in, end_of_input)
// out      output     out_valid_o / out_ready_i  out_data_o (kind, char, position, status, last)
//
// Each accepted word is judged in the cycle it is accepted, against the one character
// held back for lookahead, and its zero to four results are loaded into a result buffer.
// The buffer hands out one result per cycle while out_ready_i is high.
// A new word is taken while the last buffered result is being taken.
// Reset clears all parsing state and empties the buffer; no clearing pass is needed.
// Stalls on the output side hold the buffer and back up into in_ready_o.

module script_comment_strip_statement_split_core import scss_pkg::*; #(
  parameter int unsigned LINE_BITS   = DefLineBits,
  parameter int unsigned COLUMN_BITS = DefColumnBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  typedef enum logic [1:0] {
    PH_NORMAL,
    PH_COMMENT,
    PH_DQUOTE,
    PH_SQUOTE
  } phase_e;

  localparam int unsigned NumRes  = 4;
  localparam int unsigned NumCand = 5;

  // Parsing state.
  phase_e                 phase_q, phase_d;
  logic                   lcomment_q, lcomment_d;
  logic [7:0]             held_q, held_d;
  logic                   held_valid_q, held_valid_d;
  logic [7:0]             prev_q, prev_d;
  logic                   saw_blank_q, saw_blank_d;
  logic [7:0]             last_nb_q, last_nb_d;
  logic                   stmt_open_q, stmt_open_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;

  // Result buffer.
  out_word_t              res_q [NumRes];
  out_word_t              res_d [NumRes];
  logic [2:0]             cnt_q, cnt_d;

  logic                   in_fire, out_fire;
  logic [COLUMN_BITS-1:0] col_inc1, col_inc2;
  logic [LINE_BITS-1:0]   line_inc;
  logic [63:0]            line_ext, col_ext;

  // Handshake: buffer empty or handing out its final result.
  assign out_valid_o = (cnt_q != 3'd0);
  assign in_ready_o  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_data_o  = res_q[0];

  // Saturating position counters.
  assign col_inc1 = (col_q != '1) ? col_q + COLUMN_BITS'(1) : col_q;
  assign col_inc2 = (col_inc1 != '1) ? col_inc1 + COLUMN_BITS'(1) : col_inc1;
  assign line_inc = (line_q != '1) ? line_q + LINE_BITS'(1) : line_q;
  assign line_ext = 64'(line_q);
  assign col_ext  = 64'(col_q);

  // Judge the held character against the incoming one and build the result list.
  always_comb begin
    logic [7:0]  c;
    logic [7:0]  nxt;
    logic        has_next;
    logic        at_start;
    logic        consumed;
    logic        is_brace;
    logic        so_pre;
    logic [7:0]  quote;
    logic        cv [NumCand];
    out_word_t   cw [NumCand];
    logic [2:0]  n;

    phase_d      = phase_q;
    lcomment_d   = lcomment_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    prev_d       = prev_q;
    saw_blank_d  = saw_blank_q;
    last_nb_d    = last_nb_q;
    stmt_open_d  = stmt_open_q;
    line_d       = line_q;
    col_d        = col_q;

    c        = held_q;
    nxt      = in_data_i.char_in;
    has_next = !in_data_i.end_of_input && (nxt != CH_NEWLINE);
    at_start = (col_q == COLUMN_BITS'(1));
    consumed = 1'b0;
    is_brace = (c == CH_LBRACE);
    so_pre   = stmt_open_q;
    quote    = (phase_q == PH_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;

    for (int i = 0; i < NumCand; i++) begin
      cv[i] = 1'b0;
      cw[i] = '0;
    end
    // Candidate slots in emission order: space, early end, character, end, status.
    cw[0].out_kind = KIND_CHAR;
    cw[0].out_char = CH_SPACE;
    cw[1].out_kind = KIND_END;
    cw[2].out_kind = KIND_CHAR;
    cw[2].out_char = c;
    cw[3].out_kind = KIND_END;
    cw[4].out_kind = KIND_STATUS;

    if (held_valid_q) begin
      held_valid_d = 1'b0;
      if (!lcomment_q) begin
        unique case (phase_q)
          PH_NORMAL: begin
            if ((c == CH_SPACE) || (c == CH_TAB)) begin
              saw_blank_d = 1'b1;
            end else begin
              cv[0] = saw_blank_q && !at_start && is_alnum(last_nb_q) &&
                      (is_alnum(c) || (c == CH_DQUOTE) || (c == CH_SQUOTE));
              last_nb_d   = c;
              saw_blank_d = 1'b0;
              if ((c == CH_SLASH) && has_next && (nxt == CH_SLASH)) begin
                lcomment_d = 1'b1;
              end else if ((c == CH_SLASH) && has_next && (nxt == CH_STAR)) begin
                phase_d  = PH_COMMENT;
                consumed = 1'b1;
              end else begin
                if (c == CH_DQUOTE) phase_d = PH_DQUOTE;
                if (c == CH_SQUOTE) phase_d = PH_SQUOTE;
                // An opening brace also closes the statement before it.
                cv[1]  = is_brace && stmt_open_q;
                so_pre = stmt_open_q && !is_brace;
                cv[2]  = 1'b1;
                cv[3]  = (c == CH_SEMI) || is_brace || (c == CH_RBRACE);
                stmt_open_d = !cv[3];
              end
            end
          end
          PH_COMMENT: begin
            if ((c == CH_STAR) && has_next && (nxt == CH_SLASH)) begin
              phase_d  = PH_NORMAL;
              consumed = 1'b1;
            end
          end
          PH_DQUOTE, PH_SQUOTE: begin
            // A quote in the first column closes even after a backslash.
            if ((c == quote) && (at_start || (prev_q != CH_BSLASH))) begin
              phase_d = PH_NORMAL;
            end
            cv[2]       = 1'b1;
            stmt_open_d = 1'b1;
          end
          default: ;
        endcase
      end
      cw[2].starts_statement = !so_pre;
      if (!so_pre) begin
        cw[2].src_line   = line_ext[SrcLineW-1:0];
        cw[2].src_column = col_ext[SrcColumnW-1:0];
      end
      prev_d = consumed ? nxt : c;
      col_d  = consumed ? col_inc2 : col_inc1;
    end

    if (in_data_i.end_of_input) begin
      // Report the phase of an open statement, then return every state element to reset.
      cv[4] = 1'b1;
      if (stmt_open_d) begin
        unique case (phase_d)
          PH_COMMENT: cw[4].status = STAT_COMMENT;
          PH_NORMAL:  cw[4].status = STAT_OPEN;
          PH_DQUOTE:  cw[4].status = STAT_DQUOTE;
          PH_SQUOTE:  cw[4].status = STAT_SQUOTE;
          default:    cw[4].status = STAT_OK;
        endcase
      end else begin
        cw[4].status = STAT_OK;
      end
      phase_d      = PH_NORMAL;
      lcomment_d   = 1'b0;
      held_d       = '0;
      held_valid_d = 1'b0;
      prev_d       = '0;
      saw_blank_d  = 1'b0;
      last_nb_d    = '0;
      stmt_open_d  = 1'b0;
      line_d       = LINE_BITS'(1);
      col_d        = COLUMN_BITS'(1);
    end else if (nxt == CH_NEWLINE) begin
      lcomment_d = 1'b0;
      line_d     = line_inc;
      col_d      = COLUMN_BITS'(1);
      prev_d     = '0;
    end else if (!consumed) begin
      held_d       = nxt;
      held_valid_d = 1'b1;
    end

    // Pack the valid candidates into the front of the buffer.
    for (int i = 0; i < NumRes; i++) begin
      res_d[i] = '0;
    end
    n = 3'd0;
    for (int i = 0; i < NumCand; i++) begin
      if (cv[i]) begin
        res_d[n[1:0]] = cw[i];
        n = n + 3'd1;
      end
    end
    for (int i = 0; i < NumRes; i++) begin
      res_d[i].last = ((3'(i) + 3'd1) == n);
    end
    cnt_d = n;
  end

  // Parsing state and buffer fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_NORMAL;
      lcomment_q   <= 1'b0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      prev_q       <= '0;
      saw_blank_q  <= 1'b0;
      last_nb_q    <= '0;
      stmt_open_q  <= 1'b0;
      line_q       <= LINE_BITS'(1);
      col_q        <= COLUMN_BITS'(1);
      cnt_q        <= 3'd0;
    end else begin
      if (in_fire) begin
        phase_q      <= phase_d;
        lcomment_q   <= lcomment_d;
        held_q       <= held_d;
        held_valid_q <= held_valid_d;
        prev_q       <= prev_d;
        saw_blank_q  <= saw_blank_d;
        last_nb_q    <= last_nb_d;
        stmt_open_q  <= stmt_open_d;
        line_q       <= line_d;
        col_q        <= col_d;
        cnt_q        <= cnt_d;
      end else if (out_fire) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  // Result words: load on accept, shift toward the port as they are taken.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end else if (out_fire) begin
      for (int i = 0; i < NumRes - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  // The buffer never holds more than four words.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result buffer overfilled");

  // End of input always yields at least the status word.
  a_eoi_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.end_of_input) |=> out_valid_o)
    else $error("no result after end of input");

  // End of input returns the position counters and statement flag to reset.
  a_eoi_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.end_of_input) |=>
      (!stmt_open_q && (line_q == LINE_BITS'(1)) && (col_q == COLUMN_BITS'(1))))
    else $error("state not cleared after end of input");

  // Only characters may open a statement.
  a_start_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.out_kind != KIND_CHAR)) |-> !out_data_o.starts_statement)
    else $error("statement start on a non-character word");

  // The word in front is marked last exactly when it is the only one left.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (cnt_q == 3'd1)))
    else $error("last flag out of place");

endmodule

// ----- tb/script_comment_strip_statement_split_core_tb.sv -----
`timescale 1ns / 1ps

module script_comment_strip_statement_split_core_tb;
  import scss_pkg::*;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned MaxPerWord  = 4;
  localparam int unsigned PhaseWords  = 104;

  // Scanner phases of the predictor.
  typedef enum logic [1:0] {
    SCAN_TEXT,
    SCAN_COMMENT,
    SCAN_DQUOTE,
    SCAN_SQUOTE
  } scan_phase_e;

  // One queued source word plus the traffic settings that go with it.
  typedef struct {
    in_word_t    word;
    int unsigned send_idle;
    int unsigned recv_idle;
    bit          drain_first;
    bit          long_hold;
  } source_word_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  source_word_t source_words[$];
  out_word_t    word_results[$];
  out_word_t    awaited_results[$];

  int unsigned gen_send_idle = 0;
  int unsigned gen_recv_idle = 0;
  bit          mark_drain = 1'b0;
  bit          mark_hold = 1'b0;

  logic        in_took = 1'b0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  int unsigned errors = 0;
  int unsigned words_taken = 0;
  int unsigned results_checked = 0;
  int unsigned statements_closed = 0;
  int unsigned statuses_seen = 0;

  // Predictor state.
  scan_phase_e         scan_phase = SCAN_TEXT;
  logic                in_line_comment = 1'b0;
  logic                held_ok = 1'b0;
  logic [7:0]          held_byte = '0;
  logic [7:0]          prev_byte = '0;
  logic                blank_pending = 1'b0;
  logic [7:0]          last_mark = '0;
  logic                stmt_open = 1'b0;
  logic [SrcLineW-1:0]   line_no = 1;
  logic [SrcColumnW-1:0] col_no = 1;

  script_comment_strip_statement_split_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor of the statement splitter.
  // ---------------------------------------------------------------------------

  function automatic logic letter_or_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void reset_scanner();
    scan_phase      = SCAN_TEXT;
    in_line_comment = 1'b0;
    held_ok         = 1'b0;
    held_byte       = '0;
    prev_byte       = '0;
    blank_pending   = 1'b0;
    last_mark       = '0;
    stmt_open       = 1'b0;
    line_no         = 1;
    col_no          = 1;
  endfunction

  // A word never yields more than four results; extras are dropped.
  function automatic void add_result(input logic [1:0] kind, input logic [7:0] ch,
                                     input logic starts, input logic [SrcLineW-1:0] ln,
                                     input logic [SrcColumnW-1:0] cl, input logic [2:0] st);
    out_word_t w;
    if (word_results.size() < MaxPerWord) begin
      w.out_kind         = kind;
      w.out_char         = ch;
      w.starts_statement = starts;
      w.src_line         = ln;
      w.src_column       = cl;
      w.status           = st;
      w.last             = 1'b0;
      word_results.push_back(w);
    end
  endfunction

  // The first character of a statement carries its position.
  function automatic void put_char(input logic [7:0] c);
    if (!stmt_open) add_result(KIND_CHAR, c, 1'b1, line_no, col_no, STAT_OK);
    else add_result(KIND_CHAR, c, 1'b0, '0, '0, STAT_OK);
    stmt_open = 1'b1;
  endfunction

  function automatic void close_statement();
    add_result(KIND_END, 8'h00, 1'b0, '0, '0, STAT_OK);
    stmt_open = 1'b0;
  endfunction

  function automatic void step_column(input logic [7:0] c);
    prev_byte = c;
    if (col_no != '1) col_no = col_no + 1'b1;
  endfunction

  function automatic void break_line();
    in_line_comment = 1'b0;
    if (line_no != '1) line_no = line_no + 1'b1;
    col_no    = 1;
    prev_byte = '0;
  endfunction

  // Judges one held character against its successor; returns 1 if the
  // successor was swallowed as the second half of a comment mark.
  function automatic logic judge_byte(input logic [7:0] c, input logic has_next,
                                      input logic [7:0] nxt);
    logic       took;
    logic       at_start;
    logic [7:0] quote;
    took     = 1'b0;
    at_start = (col_no == 1);
    if (in_line_comment) begin
      took = 1'b0;
    end else if (scan_phase == SCAN_TEXT) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        blank_pending = 1'b1;
      end else begin
        // Keep one space between words separated by blanks.
        if (blank_pending && !at_start && letter_or_digit(last_mark) &&
            (letter_or_digit(c) || c == CH_DQUOTE || c == CH_SQUOTE))
          add_result(KIND_CHAR, CH_SPACE, 1'b0, '0, '0, STAT_OK);
        last_mark     = c;
        blank_pending = 1'b0;
        if (c == CH_SLASH && has_next && nxt == CH_SLASH) begin
          in_line_comment = 1'b1;
        end else if (c == CH_SLASH && has_next && nxt == CH_STAR) begin
          scan_phase = SCAN_COMMENT;
          took       = 1'b1;
        end else begin
          if (c == CH_DQUOTE) scan_phase = SCAN_DQUOTE;
          if (c == CH_SQUOTE) scan_phase = SCAN_SQUOTE;
          if (c == CH_LBRACE && stmt_open) close_statement();
          put_char(c);
          if (c == CH_SEMI || c == CH_LBRACE || c == CH_RBRACE) close_statement();
        end
      end
    end else if (scan_phase == SCAN_COMMENT) begin
      if (c == CH_STAR && has_next && nxt == CH_SLASH) begin
        scan_phase = SCAN_TEXT;
        took       = 1'b1;
      end
    end else begin
      quote = (scan_phase == SCAN_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
      if (c == quote && (at_start || prev_byte != CH_BSLASH)) scan_phase = SCAN_TEXT;
      put_char(c);
    end
    step_column(c);
    if (took) step_column(nxt);
    return took;
  endfunction

  // Works out every result of one accepted word and queues them.
  function automatic void predict_word(input in_word_t w);
    logic       took;
    logic [2:0] st;
    word_results.delete();
    if (w.end_of_input) begin
      st = STAT_OK;
      if (held_ok) took = judge_byte(held_byte, 1'b0, 8'h00);
      held_ok = 1'b0;
      if (stmt_open) begin
        case (scan_phase)
          SCAN_COMMENT: st = STAT_COMMENT;
          SCAN_TEXT:    st = STAT_OPEN;
          SCAN_DQUOTE:  st = STAT_DQUOTE;
          default:      st = STAT_SQUOTE;
        endcase
      end
      add_result(KIND_STATUS, 8'h00, 1'b0, '0, '0, st);
      reset_scanner();
    end else begin
      took = 1'b0;
      if (held_ok) begin
        held_ok = 1'b0;
        took    = judge_byte(held_byte, w.char_in != CH_NEWLINE, w.char_in);
      end
      if (w.char_in == CH_NEWLINE) begin
        break_line();
      end else if (!took) begin
        held_byte = w.char_in;
        held_ok   = 1'b1;
      end
    end
    if (word_results.size() != 0) word_results[word_results.size() - 1].last = 1'b1;
    foreach (word_results[i]) awaited_results.push_back(word_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  function automatic void queue_word(input logic [7:0] ch, input logic eoi);
    source_word_t sw;
    sw.word.char_in      = ch;
    sw.word.end_of_input = eoi;
    sw.send_idle         = gen_send_idle;
    sw.recv_idle         = gen_recv_idle;
    sw.drain_first       = mark_drain;
    sw.long_hold         = mark_hold;
    mark_drain           = 1'b0;
    mark_hold            = 1'b0;
    source_words.push_back(sw);
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_word(s[i], 1'b0);
  endfunction

  // The byte that rides along with an end-of-input mark is random.
  function automatic void queue_eof();
    queue_word(8'($urandom_range(255)), 1'b1);
  endfunction

  function automatic logic [7:0] pick_alnum();
    int unsigned k;
    k = $urandom_range(61);
    if (k < 10) return 8'("0" + k);
    else if (k < 36) return 8'("A" + k - 10);
    else return 8'("a" + k - 36);
  endfunction

  function automatic logic [7:0] content_byte();
    if ($urandom_range(99) < 65) return pick_alnum();
    else return 8'($urandom_range(255));
  endfunction

  // Appends one token of script text.
  function automatic void random_token();
    int unsigned r;
    int unsigned n;
    logic [7:0]  q;
    logic [7:0]  ops[8];
    ops = '{"+", "-", "=", "(", ")", ",", ".", "*"};
    r = $urandom_range(99);
    if (r < 22) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) queue_word(pick_alnum(), 1'b0);
    end else if (r < 32) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) queue_word($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
    end else if (r < 42) begin
      n = $urandom_range(2);
      queue_word(n == 0 ? CH_SEMI : (n == 1 ? CH_LBRACE : CH_RBRACE), 1'b0);
    end else if (r < 50) begin
      queue_word(CH_NEWLINE, 1'b0);
    end else if (r < 63) begin
      // Quoted string, sometimes with escaped quotes, sometimes left open.
      q = (r < 58) ? CH_DQUOTE : CH_SQUOTE;
      queue_word(q, 1'b0);
      n = $urandom_range(4);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(5) == 0) begin
          queue_word(CH_BSLASH, 1'b0);
          queue_word(q, 1'b0);
        end else begin
          queue_word(($urandom_range(9) == 0) ? CH_NEWLINE : content_byte(), 1'b0);
        end
      end
      if ($urandom_range(99) < 88) queue_word(q, 1'b0);
    end else if (r < 69) begin
      queue_word(CH_SLASH, 1'b0);
      queue_word(CH_SLASH, 1'b0);
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) queue_word(content_byte(), 1'b0);
      queue_word(CH_NEWLINE, 1'b0);
    end else if (r < 76) begin
      queue_word(CH_SLASH, 1'b0);
      queue_word(CH_STAR, 1'b0);
      n = $urandom_range(4);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(5))
          0:       queue_word(CH_STAR, 1'b0);
          1:       queue_word(CH_NEWLINE, 1'b0);
          default: queue_word(content_byte(), 1'b0);
        endcase
      end
      if ($urandom_range(99) < 85) begin
        queue_word(CH_STAR, 1'b0);
        queue_word(CH_SLASH, 1'b0);
      end
    end else if (r < 82) begin
      queue_word($urandom_range(1) ? CH_SLASH : CH_STAR, 1'b0);
    end else if (r < 88) begin
      queue_word(ops[$urandom_range(7)], 1'b0);
    end else if (r < 96) begin
      queue_word(8'($urandom_range(255)), 1'b0);
    end else begin
      queue_eof();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking.
  // ---------------------------------------------------------------------------

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(input out_word_t got);
    out_word_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result word, expected none, got %h", $time, got);
      errors++;
    end else begin
      want = awaited_results.pop_front();
      compare_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
      compare_field("out_char", 32'(want.out_char), 32'(got.out_char));
      compare_field("starts_statement", 32'(want.starts_statement),
                    32'(got.starts_statement));
      compare_field("src_line", 32'(want.src_line), 32'(got.src_line));
      compare_field("src_column", 32'(want.src_column), 32'(got.src_column));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("last", 32'(want.last), 32'(got.last));
      if (want.out_kind == KIND_END) statements_closed++;
      if (want.out_kind == KIND_STATUS) statuses_seen++;
    end
    results_checked++;
  endfunction

  // Outputs are checked before the word taken at the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) begin
        predict_word(in_data);
        words_taken++;
      end
      in_took <= in_valid && in_ready;
    end
  end

  // Input driver: offers the next queued word, idling at random.
  always @(negedge clk) begin : drive_words
    source_word_t sw;
    if (rst_n && (!in_valid || in_took)) begin
      if (source_words.size() != 0 &&
          !(source_words[0].drain_first && awaited_results.size() != 0) &&
          ($urandom_range(99) >= source_words[0].send_idle)) begin
        sw = source_words.pop_front();
        in_data       <= sw.word;
        in_valid      <= 1'b1;
        recv_idle_pct <= sw.recv_idle;
        if (sw.long_hold) hold_requests <= hold_requests + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls plus the occasional long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HoldCycles;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------

  initial begin : run
    int unsigned counted;
    int unsigned base;
    reset_scanner();

    // Directed text: blanks and tabs, braces, escaped and line-start quotes,
    // comments, bytes zero and 255, and every end-of-input status.
    gen_send_idle = 29;
    gen_recv_idle = 68;
    queue_text("a\tb{};\n");
    queue_text("\"\\\"x\\\n\"");
    queue_text("/**/b//\n");
    queue_eof();
    queue_word(CH_SQUOTE, 1'b0);
    queue_word(8'h00, 1'b0);
    queue_word(8'hFF, 1'b0);
    queue_eof();
    queue_text("x/*");
    queue_eof();
    queue_text("\"");
    queue_eof();
    queue_eof();

    // Three random phases with different idling on each side.
    for (int p = 0; p < 3; p++) begin
      gen_send_idle = (p == 0) ? 29 : ((p == 1) ? 68 : 0);
      gen_recv_idle = (p == 0) ? 68 : ((p == 1) ? 29 : 0);
      mark_drain    = 1'b1;
      base          = source_words.size();
      counted       = 0;
      while (counted < PhaseWords) begin
        if (p != 1 && counted >= 40 && counted < 45) mark_hold = 1'b1;
        random_token();
        counted = source_words.size() - base;
      end
      mark_hold = 1'b0;
      queue_eof();
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (source_words.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d source words; checked %0d results, %0d statement ends,",
             words_taken, results_checked, statements_closed);
    $display("%0d end-of-input statuses, with long output stalls and drained pauses.",
             statuses_seen);
    if (errors == 0) begin
      $display("script_comment_strip_statement_split_core_tb: done, clean");
    end else begin
      $display("script_comment_strip_statement_split_core_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(6_000_000);
    $display("script_comment_strip_statement_split_core_tb: done, errors");
    $finish;
  end

endmodule
